// ===== rtl/core/bch_syn_pkg.sv =====
`default_nettype none

package bch_syn_pkg;

	localparam int FIELD_BITS_DEF = 10;
	localparam int MAX_SYN_DEF    = 3;

	localparam int POLY_W    = 11;
	localparam int SHORT_W   = 10;
	localparam int NSYN_W    = 2;
	localparam int SYN_W     = 10;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = POLY_W;

	localparam logic [POLY_W-1:0]  FIELD_POLY_RST = POLY_W'(1033);
	localparam logic [SHORT_W-1:0] SHORTEN_RST    = '0;
	localparam logic [NSYN_W-1:0]  NUM_SYN_RST    = NSYN_W'(3);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FIELD_POLY = 2'd0,
		CFG_SHORTEN    = 2'd1,
		CFG_NUM_SYN    = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [SYN_W-1:0] syn_one;
		logic [SYN_W-1:0] syn_three;
		logic [SYN_W-1:0] syn_five;
		logic             all_zero;
	} syn_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/bch_syn_step.sv =====
`default_nettype none

module bch_syn_step #(
	parameter int FIELD_BITS = bch_syn_pkg::FIELD_BITS_DEF,
	parameter int STRIDE     = 1
) (
	input  logic [FIELD_BITS-1:0] red,
	input  logic [FIELD_BITS-1:0] exp_cur,
	input  logic [FIELD_BITS-1:0] pow_cur,
	output logic [FIELD_BITS-1:0] exp_next,
	output logic [FIELD_BITS-1:0] pow_next
);

	localparam int FW = FIELD_BITS;
	localparam logic [FW:0] PRIM_LEN = {1'b0, {FW{1'b1}}};

	// multiply by alpha: shift up and fold the top bit back through the polynomial
	function automatic logic [FW-1:0] mul_x(input logic [FW-1:0] a, input logic [FW-1:0] r);
		mul_x = {a[FW-2:0], 1'b0} ^ (a[FW-1] ? r : '0);
	endfunction

	logic [FW:0]   exp_sum;
	logic [FW:0]   exp_wrap;
	logic          wrap;
	logic [FW-1:0] pow_adv [STRIDE+1];
	logic [FW-1:0] pow_low [STRIDE];
	logic [FW-1:0] pow_wrap;

	always_comb begin
		exp_sum  = {1'b0, exp_cur} + (FW+1)'(STRIDE);
		wrap     = exp_sum >= PRIM_LEN;
		exp_wrap = exp_sum - PRIM_LEN;

		pow_adv[0] = pow_cur;
		for (int j = 0; j < STRIDE; j++) begin
			pow_adv[j+1] = mul_x(pow_adv[j], red);
		end

		// after the exponent wraps it is below the stride, so take alpha^e directly
		pow_low[0] = FW'(1);
		for (int j = 1; j < STRIDE; j++) begin
			pow_low[j] = mul_x(pow_low[j-1], red);
		end
		pow_wrap = pow_low[0];
		for (int j = 0; j < STRIDE; j++) begin
			if (exp_wrap == (FW+1)'(j)) begin
				pow_wrap = pow_low[j];
			end
		end

		exp_next = wrap ? exp_wrap[FW-1:0] : exp_sum[FW-1:0];
		pow_next = wrap ? pow_wrap : pow_adv[STRIDE];
	end

endmodule

`default_nettype wire

// ===== rtl/core/bch_syn_outq.sv =====
`default_nettype none

module bch_syn_outq (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  bch_syn_pkg::syn_result_t  push_data,
	input  logic                      out_stall,
	output logic                      out_valid,
	output bch_syn_pkg::syn_result_t  out_data,
	output logic                      pop,
	output logic [1:0]                level
);

	bch_syn_pkg::syn_result_t entry_q [2];
	logic                     wr_ptr_q;
	logic                     rd_ptr_q;
	logic [1:0]               cnt_q;

	assign out_valid = cnt_q != 2'd0;
	assign out_data  = entry_q[rd_ptr_q];
	assign pop       = out_valid & ~out_stall;
	assign level     = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/bch_syndrome_stream_core.sv =====
`default_nettype none

// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+------------------------------------------
// in       | sink      | in_valid/in_stall  | code_bit, last_bit
// out      | source    | out_valid/out_stall| syndrome_one/three/five, all_zero
// cfg      | sink      | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// one code bit per cycle when not stalled: the bit is registered, then folded into the
// syndromes against powers alpha^((2i+1)p) that advance by a constant multiply per bit
// a last bit's result enters a two-entry output queue in the cycle after its transfer
// a config write recomputes the running powers by stepping from position zero up to
// min(bit position + shorten_count, 2^FIELD_BITS - 1), with input stalled; reset needs
// no clearing pass; input stalls on cfg_valid or if the output queue would overflow

module bch_syndrome_stream_core #(
	parameter int FIELD_BITS    = bch_syn_pkg::FIELD_BITS_DEF,
	parameter int MAX_SYNDROMES = bch_syn_pkg::MAX_SYN_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                code_bit,
	input  logic                                last_bit,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [bch_syn_pkg::SYN_W-1:0]       syndrome_one,
	output logic [bch_syn_pkg::SYN_W-1:0]       syndrome_three,
	output logic [bch_syn_pkg::SYN_W-1:0]       syndrome_five,
	output logic                                all_zero,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bch_syn_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bch_syn_pkg::CFG_W-1:0]       cfg_data
);

	localparam int FW      = FIELD_BITS;
	localparam int MS      = MAX_SYNDROMES;
	localparam int POS_W   = FW + 1;
	localparam int SHORT_W = bch_syn_pkg::SHORT_W;
	localparam int PSUM_W  = ((POS_W > SHORT_W) ? POS_W : SHORT_W) + 1;
	localparam int SYN_W   = bch_syn_pkg::SYN_W;
	localparam logic [FW-1:0]    PRIM_LEN = {FW{1'b1}};
	localparam logic [POS_W-1:0] POS_MAX  = {POS_W{1'b1}};

	// configuration
	logic [bch_syn_pkg::POLY_W-1:0] field_poly_q;
	logic [SHORT_W-1:0]             shorten_q;
	logic [bch_syn_pkg::NSYN_W-1:0] num_syn_q;

	// input stage
	logic valid_s1;
	logic code_bit_s1;
	logic last_bit_s1;

	// running state
	logic [POS_W-1:0] bit_pos_q;
	logic [FW-1:0]    exp_q      [MS];
	logic [FW-1:0]    pow_q      [MS];
	logic [FW-1:0]    base_exp_q [MS];
	logic [FW-1:0]    base_pow_q [MS];
	logic [FW-1:0]    acc_q      [MS];
	logic             replay_q;
	logic [FW-1:0]    rcnt_q;

	logic [FW-1:0]     exp_nx [MS];
	logic [FW-1:0]     pow_nx [MS];
	logic [FW-1:0]     acc_fin [MS];
	logic [FW-1:0]     red;
	logic [PSUM_W-1:0] pos;
	logic              in_range;
	logic [FW-1:0]     target;
	logic              replay_done;
	logic              at_shorten;
	logic              cfg_we;
	logic              in_accept;
	logic              hit;
	logic              push;
	logic              pop;
	logic [1:0]        level;
	logic [2:0]        occupancy;
	logic [1:0]        num_eff;
	logic [SYN_W-1:0]  res_syn [3];
	logic              res_zero;

	bch_syn_pkg::syn_result_t res;
	bch_syn_pkg::syn_result_t out_data;

	assign red         = FW'(field_poly_q);
	assign pos         = PSUM_W'(bit_pos_q) + PSUM_W'(shorten_q);
	assign in_range    = pos < PSUM_W'(PRIM_LEN);
	assign target      = in_range ? FW'(pos) : PRIM_LEN;
	assign replay_done = rcnt_q == target;
	assign at_shorten  = PSUM_W'(rcnt_q) == PSUM_W'(shorten_q);
	assign hit         = code_bit_s1 & in_range;
	assign push        = valid_s1 & last_bit_s1;

	assign cfg_ready = ~replay_q & ~valid_s1;
	assign cfg_we    = cfg_valid & cfg_ready;

	// queue room once the item in the input stage has landed
	assign occupancy = 3'(level) + 3'(push) - 3'(pop);
	assign in_stall  = replay_q | cfg_valid | (occupancy >= 3'd2);
	assign in_accept = in_valid & ~in_stall;

	for (genvar i = 0; i < MS; i++) begin : g_lane
		bch_syn_step #(
			.FIELD_BITS(FW),
			.STRIDE    (2 * i + 1)
		) u_step (
			.red     (red),
			.exp_cur (exp_q[i]),
			.pow_cur (pow_q[i]),
			.exp_next(exp_nx[i]),
			.pow_next(pow_nx[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_poly_q <= bch_syn_pkg::FIELD_POLY_RST;
			shorten_q    <= bch_syn_pkg::SHORTEN_RST;
			num_syn_q    <= bch_syn_pkg::NUM_SYN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bch_syn_pkg::CFG_FIELD_POLY: field_poly_q <= cfg_data;
				bch_syn_pkg::CFG_SHORTEN:    shorten_q    <= SHORT_W'(cfg_data);
				bch_syn_pkg::CFG_NUM_SYN:    num_syn_q    <= bch_syn_pkg::NSYN_W'(cfg_data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			code_bit_s1 <= code_bit;
			last_bit_s1 <= last_bit;
		end
	end

	// replay: step the lanes from position zero up to the current position,
	// capturing the codeword start values on the way
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			replay_q <= 1'b0;
			rcnt_q   <= '0;
		end else if (cfg_we) begin
			replay_q <= 1'b1;
			rcnt_q   <= '0;
		end else if (replay_q) begin
			if (replay_done) begin
				replay_q <= 1'b0;
			end else begin
				rcnt_q <= rcnt_q + FW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_pos_q <= '0;
		end else if (valid_s1) begin
			if (last_bit_s1) begin
				bit_pos_q <= '0;
			end else if (bit_pos_q != POS_MAX) begin
				bit_pos_q <= bit_pos_q + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MS; i++) begin
				exp_q[i]      <= '0;
				pow_q[i]      <= FW'(1);
				base_exp_q[i] <= '0;
				base_pow_q[i] <= FW'(1);
				acc_q[i]      <= '0;
			end
		end else begin
			for (int i = 0; i < MS; i++) begin
				if (cfg_we) begin
					exp_q[i] <= '0;
					pow_q[i] <= FW'(1);
				end else if (replay_q) begin
					if (at_shorten) begin
						base_exp_q[i] <= exp_q[i];
						base_pow_q[i] <= pow_q[i];
					end
					if (!replay_done) begin
						exp_q[i] <= exp_nx[i];
						pow_q[i] <= pow_nx[i];
					end
				end else if (valid_s1) begin
					if (last_bit_s1) begin
						exp_q[i] <= base_exp_q[i];
						pow_q[i] <= base_pow_q[i];
						acc_q[i] <= '0;
					end else begin
						exp_q[i] <= exp_nx[i];
						pow_q[i] <= pow_nx[i];
						acc_q[i] <= acc_fin[i];
					end
				end
			end
		end
	end

	always_comb begin
		num_eff = num_syn_q;
		if (num_eff == 2'd0) begin
			num_eff = 2'd1;
		end
		if (num_eff > 2'(MS)) begin
			num_eff = 2'(MS);
		end

		res_zero = 1'b1;
		for (int i = 0; i < 3; i++) begin
			res_syn[i] = '0;
		end
		for (int i = 0; i < MS; i++) begin
			acc_fin[i] = acc_q[i] ^ (hit ? pow_q[i] : '0);
			if (2'(i) < num_eff) begin
				res_syn[i] = SYN_W'(acc_fin[i]);
				if (acc_fin[i] != '0) begin
					res_zero = 1'b0;
				end
			end
		end

		res.syn_one   = res_syn[0];
		res.syn_three = res_syn[1];
		res.syn_five  = res_syn[2];
		res.all_zero  = res_zero;
	end

	bch_syn_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(res),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_data (out_data),
		.pop      (pop),
		.level    (level)
	);

	assign syndrome_one   = out_data.syn_one;
	assign syndrome_three = out_data.syn_three;
	assign syndrome_five  = out_data.syn_five;
	assign all_zero       = out_data.all_zero;

endmodule

`default_nettype wire
